// File: design/irn_pkg.sv
// Shared types, letter codes and the microcode table for the integer to Roman numeral unit.
// Depends on nothing; every other design file imports it.
package irn_pkg;

   localparam int NumberWidth = 12;
   localparam int ValueWidth  = 10;
   localparam int LetterWidth = 8;
   localparam int PcWidth     = 5;

   typedef logic [PcWidth-1:0]     pc_type;
   typedef logic [NumberWidth-1:0] number_type;
   typedef logic [LetterWidth-1:0] letter_type;

   // Micro-operations.
   localparam logic OP_TEST = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   // ASCII codes of the numeral letters.
   localparam letter_type CharM    = 8'h4D;
   localparam letter_type CharD    = 8'h44;
   localparam letter_type CharC    = 8'h43;
   localparam letter_type CharL    = 8'h4C;
   localparam letter_type CharX    = 8'h58;
   localparam letter_type CharV    = 8'h56;
   localparam letter_type CharI    = 8'h49;
   localparam letter_type CharNone = 8'h00;

   // One control word. A test step compares the remainder with value and, when it is not
   // smaller, emits letter, subtracts value and goes to hit_pc; otherwise it goes to miss_pc.
   // An emit step sends the second letter of a pair and goes to hit_pc.
   typedef struct packed {
      logic                  op;
      logic [ValueWidth-1:0] value;
      letter_type            letter;
      logic                  second;
      pc_type                hit_pc;
      pc_type                miss_pc;
   } uword_type;

   typedef struct packed {
      logic      load;
      logic      active;
      uword_type word;
   } irn_ctrl_type;

   typedef struct packed {
      logic hit;
      logic done;
   } irn_status_type;

   function automatic uword_type ucode_rom(pc_type pc);
      uword_type w;
      case (pc)
         5'd0:    w = '{OP_TEST, 10'd1000, CharM, 1'b0, 5'd0,  5'd1};
         5'd1:    w = '{OP_TEST, 10'd900,  CharC, 1'b1, 5'd2,  5'd3};
         5'd2:    w = '{OP_EMIT, 10'd0,    CharM, 1'b0, 5'd1,  5'd1};
         5'd3:    w = '{OP_TEST, 10'd500,  CharD, 1'b0, 5'd3,  5'd4};
         5'd4:    w = '{OP_TEST, 10'd400,  CharC, 1'b1, 5'd5,  5'd6};
         5'd5:    w = '{OP_EMIT, 10'd0,    CharD, 1'b0, 5'd4,  5'd4};
         5'd6:    w = '{OP_TEST, 10'd100,  CharC, 1'b0, 5'd6,  5'd7};
         5'd7:    w = '{OP_TEST, 10'd90,   CharX, 1'b1, 5'd8,  5'd9};
         5'd8:    w = '{OP_EMIT, 10'd0,    CharC, 1'b0, 5'd7,  5'd7};
         5'd9:    w = '{OP_TEST, 10'd50,   CharL, 1'b0, 5'd9,  5'd10};
         5'd10:   w = '{OP_TEST, 10'd40,   CharX, 1'b1, 5'd11, 5'd12};
         5'd11:   w = '{OP_EMIT, 10'd0,    CharL, 1'b0, 5'd10, 5'd10};
         5'd12:   w = '{OP_TEST, 10'd10,   CharX, 1'b0, 5'd12, 5'd13};
         5'd13:   w = '{OP_TEST, 10'd9,    CharI, 1'b1, 5'd14, 5'd15};
         5'd14:   w = '{OP_EMIT, 10'd0,    CharX, 1'b0, 5'd13, 5'd13};
         5'd15:   w = '{OP_TEST, 10'd5,    CharV, 1'b0, 5'd15, 5'd16};
         5'd16:   w = '{OP_TEST, 10'd4,    CharI, 1'b1, 5'd17, 5'd18};
         5'd17:   w = '{OP_EMIT, 10'd0,    CharV, 1'b0, 5'd16, 5'd16};
         5'd18:   w = '{OP_TEST, 10'd1,    CharI, 1'b0, 5'd18, 5'd18};
         default: w = '{OP_TEST, 10'd1,    CharI, 1'b0, 5'd18, 5'd18};
      endcase
      return w;
   endfunction

endpackage

// File: design/integer_to_roman_numeral_unit.sv
// Integer to Roman numeral unit: one request in, a stream of strobed ASCII letters out.
// Once a request is taken the sequencer steps through the table: each matching test
// and each emit step strobes one registered letter, a failed test strobes none. Zero
// gives its empty result in the cycle after it is taken, with no program run, and
// leaves busy low. Busy drops with the last letter; no request is taken while busy.
// Reset (synchronous, active high) returns the sequencer to idle and drops the strobe.
// Depends on irn_pkg, irn_sequencer and irn_datapath.
module integer_to_roman_numeral_unit
   import irn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  number_type req_number,
   output logic       rsp_strobe,
   output letter_type rsp_symbol,
   output logic       rsp_last,
   output logic       rsp_empty_res
);

   irn_ctrl_type   ctrl;
   irn_status_type status;

   irn_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .number_zero (req_number == '0),
      .status      (status),
      .ctrl        (ctrl),
      .busy        (busy)
   );

   irn_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .req_number    (req_number),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_symbol    (rsp_symbol),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

   // The end of a program run always delivers the final letter.
   a_busy_end_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_strobe && rsp_last))
      else $error("busy fell without a final letter");

   // A zero request is answered next cycle with the single empty result.
   a_zero_empty: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_number == '0) |=> (rsp_strobe && rsp_empty_res && rsp_last))
      else $error("zero request not answered with an empty result");

   // A letter that is not final leaves the program running.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("non-final letter while idle");

   // An empty result carries no letter.
   a_empty_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_empty_res) |-> (rsp_symbol == CharNone && rsp_last))
      else $error("empty result carries a letter");

endmodule

// File: design/irn_sequencer.sv
// Microcode sequencer: step counter, control store lookup and branch selection.
// Depends on irn_pkg for the control word layout and the microcode table.
module irn_sequencer
   import irn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           number_zero,
   input  irn_status_type status,
   output irn_ctrl_type   ctrl,
   output logic           busy
);

   logic   busy_ff, busy_in;
   pc_type pc_ff, pc_in;
   logic   accept;

   assign accept = start && !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (accept) begin
         // A zero request is answered by the datapath on its own and needs no program run.
         busy_in = !number_zero;
         pc_in   = '0;
      end else if (busy_ff) begin
         if (status.done) begin
            busy_in = 1'b0;
         end
         if (ctrl.word.op == OP_EMIT || status.hit) begin
            pc_in = ctrl.word.hit_pc;
         end else begin
            pc_in = ctrl.word.miss_pc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctrl.load   = accept;
   assign ctrl.active = busy_ff;
   assign ctrl.word   = ucode_rom(pc_ff);
   assign busy        = busy_ff;

endmodule

// File: design/irn_datapath.sv
// Datapath: remainder register, compare and subtract, and the registered result port.
// Depends on irn_pkg; driven by the control word from irn_sequencer.
module irn_datapath
   import irn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  irn_ctrl_type   ctrl,
   input  number_type     req_number,
   output irn_status_type status,
   output logic           rsp_strobe,
   output letter_type     rsp_symbol,
   output logic           rsp_last,
   output logic           rsp_empty_res
);

   number_type rest_ff, rest_in;
   number_type rest_after;
   number_type step_value;
   logic       hit;
   logic       emit;
   logic       done;
   logic       strobe_ff, strobe_in;
   letter_type symbol_ff, symbol_in;
   logic       last_ff, last_in;
   logic       empty_ff, empty_in;

   assign step_value = {{(NumberWidth-ValueWidth){1'b0}}, ctrl.word.value};
   assign hit        = rest_ff >= step_value;
   assign emit       = ctrl.active && (ctrl.word.op == OP_EMIT || hit);
   assign rest_after = (ctrl.word.op == OP_TEST) ? (rest_ff - step_value) : rest_ff;
   // The letter is final once nothing remains and no second letter of a pair follows.
   assign done       = emit && (rest_after == '0) &&
                       !(ctrl.word.op == OP_TEST && ctrl.word.second);

   always_comb begin
      rest_in   = rest_ff;
      strobe_in = 1'b0;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      empty_in  = empty_ff;
      if (ctrl.load) begin
         rest_in = req_number;
         if (req_number == '0) begin
            strobe_in = 1'b1;
            symbol_in = CharNone;
            last_in   = 1'b1;
            empty_in  = 1'b1;
         end
      end else if (emit) begin
         rest_in   = rest_after;
         strobe_in = 1'b1;
         symbol_in = ctrl.word.letter;
         last_in   = done;
         empty_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      rest_ff   <= rest_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
   end

   assign status.hit     = hit;
   assign status.done    = done;
   assign rsp_strobe     = strobe_ff;
   assign rsp_symbol     = symbol_ff;
   assign rsp_last       = last_ff;
   assign rsp_empty_res  = empty_ff;

endmodule

// File: tb/tb.sv
// Self-checking testbench for integer_to_roman_numeral_unit: directed and random requests,
// each spelt out by a local greedy predictor and checked letter by letter on the strobe.
// Depends on irn_pkg and the design files of the unit.
`timescale 1ns / 1ps

module tb;
   import irn_pkg::*;

   localparam int MaxLetters  = 15;
   localparam int CycleLimit  = 200000;
   localparam int TailCycles  = 40;
   localparam int RandomItems = 86;

   typedef struct {
      letter_type symbol;
      logic       last;
      logic       empty_res;
   } letter_due_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   number_type req_number = '0;
   logic       rsp_strobe;
   letter_type rsp_symbol;
   logic       rsp_last;
   logic       rsp_empty_res;

   number_type     pending_numbers[$];
   letter_due_type letters_due[$];
   logic           taken = 1'b0;
   int             idle_pct = 0;
   int             mismatches = 0;
   int             cycles = 0;
   int             requests_done = 0;
   int             zero_requests = 0;
   int             high_requests = 0;
   int             letters_checked = 0;

   // Greedy table, largest value first; a second letter of none marks a single-letter entry.
   int         roman_value [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
   letter_type first_letter [13] = '{CharM, CharC, CharD, CharC, CharC, CharX, CharL,
                                     CharX, CharX, CharI, CharV, CharI, CharI};
   letter_type second_letter [13] = '{CharNone, CharM, CharNone, CharD, CharNone, CharC,
                                      CharNone, CharL, CharNone, CharX, CharNone, CharV,
                                      CharNone};

   integer_to_roman_numeral_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_number    (req_number),
      .rsp_strobe    (rsp_strobe),
      .rsp_symbol    (rsp_symbol),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void spell_roman(number_type number);
      int             rest;
      int             count;
      letter_due_type letter;
      rest = number;
      count = 0;
      letter.last = 1'b0;
      letter.empty_res = 1'b0;
      if (rest == 0) begin
         letter.symbol = CharNone;
         letter.last = 1'b1;
         letter.empty_res = 1'b1;
         letters_due.push_back(letter);
         return;
      end
      for (int e = 0; e < 13; e++) begin
         while (rest >= roman_value[e] && count < MaxLetters) begin
            letter.symbol = first_letter[e];
            letters_due.push_back(letter);
            count++;
            if (second_letter[e] != CharNone && count < MaxLetters) begin
               letter.symbol = second_letter[e];
               letters_due.push_back(letter);
               count++;
            end
            rest -= roman_value[e];
         end
      end
      letters_due[letters_due.size()-1].last = 1'b1;
   endfunction

   function automatic int long_digit();
      int pick;
      pick = $urandom_range(2);
      return (pick == 0) ? 3 : (pick == 1) ? 7 : 8;
   endfunction

   task automatic note_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      mismatches++;
   endtask

   // Driver: a request is held until taken, then the next one is offered or start drops.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (pending_numbers.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_number <= pending_numbers.pop_front();
         end else begin
            start <= 1'b0;
            req_number <= number_type'($urandom);
         end
      end
   end

   // Monitor: predicts on each taken request and checks every strobed letter.
   always @(posedge clock) begin
      letter_due_type want;
      cycles <= cycles + 1;
      taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         spell_roman(req_number);
         requests_done++;
         if (req_number == 0) zero_requests++;
         if (req_number > 3999) high_requests++;
      end
      if (!reset && rsp_strobe) begin
         if (letters_due.size() == 0) begin
            note_mismatch("unexpected letter", rsp_symbol, 0);
         end else begin
            want = letters_due.pop_front();
            letters_checked++;
            if (rsp_symbol !== want.symbol) note_mismatch("symbol", rsp_symbol, want.symbol);
            if (rsp_last !== want.last) note_mismatch("last", rsp_last, want.last);
            if (rsp_empty_res !== want.empty_res)
               note_mismatch("empty_res", rsp_empty_res, want.empty_res);
         end
      end
      if (cycles > CycleLimit) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      int phase_idle [4];
      int kind;
      phase_idle = '{0, 56, 0, 31};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extremes, every table entry, the longest numeral and values above 3999.
      pending_numbers = '{0, 1, 4, 5, 9, 10, 40, 50, 90, 100, 400, 500, 900, 1000, 3999,
                          3888, 1994, 2048, 1111, 3444, 4000, 4088, 4095, 2730, 1365};
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = phase_idle[phase];
         for (int n = 0; n < RandomItems; n++) begin
            kind = $urandom_range(9);
            if (kind == 0)
               pending_numbers.push_back('0);
            else if (kind == 1)
               pending_numbers.push_back(number_type'($urandom_range(4095, 4000)));
            else if (kind == 2)
               pending_numbers.push_back(number_type'($urandom_range(3) * 1000
                                         + long_digit() * 100 + long_digit() * 10
                                         + long_digit()));
            else
               pending_numbers.push_back(number_type'($urandom_range(3999, 1)));
         end
         while (pending_numbers.size() != 0 || start || letters_due.size() != 0)
            @(negedge clock);
      end

      repeat (TailCycles) @(negedge clock);
      $display("%0d requests converted, %0d of them zero and %0d above 3999,", requests_done,
               zero_requests, high_requests);
      $display("%0d letters checked over four pacing phases, %0d mismatches", letters_checked,
               mismatches);
      if (mismatches == 0 && letters_due.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// File: files.f
design/irn_pkg.sv
design/irn_sequencer.sv
design/irn_datapath.sv
design/integer_to_roman_numeral_unit.sv
tb/tb.sv
